[design/longest_common_substring_stream_core_assert.svh]
// ----------------------------------------------------------------------------
// assertion macros for the longest common substring stream core
// each macro expands to one labeled concurrent assertion on clk and rst_n
// ----------------------------------------------------------------------------
`ifndef LONGEST_COMMON_SUBSTRING_STREAM_CORE_ASSERT_SVH
`define LONGEST_COMMON_SUBSTRING_STREAM_CORE_ASSERT_SVH

// condition must hold at every edge out of reset
`define LCSS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// consequence must hold in the same cycle as the trigger
`define LCSS_ASSERT_SAME(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// consequence must hold in the cycle after the trigger
`define LCSS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

[design/lcss_pkg.sv]
// ----------------------------------------------------------------------------
// lcss_pkg
// shared types and constants of the longest common substring stream core
// ----------------------------------------------------------------------------
package lcss_pkg;

  // command codes on the input channel
  localparam logic CMD_QUERY = 1'b0;
  localparam logic CMD_LINE  = 1'b1;

  // printable byte range
  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] PRINT_HI = 8'h7E;

  // result field widths and their clamp values
  localparam int MATCH_W     = 8;
  localparam int LINE_BYTES_W = 11;
  localparam int MATCH_MAX   = 255;
  localparam int BYTES_MAX   = 2047;

  // control broadcast from the sequencer to every cell of the row
  typedef struct packed {
    logic       clear;     // drop all line state
    logic       step;      // printable line byte: update run lengths
    logic       wr_en;     // query byte is being stored
    logic       restart;   // query byte starts a new query
    logic [7:0] byte_val;  // current byte
  } cell_ctrl_t;

endpackage

[design/lcss_cell.sv]
// ----------------------------------------------------------------------------
// lcss_cell
// one query position: stored byte, run length ending here, running best
// ----------------------------------------------------------------------------
module lcss_cell #(
  parameter int RUN_W = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lcss_pkg::cell_ctrl_t ctrl,
  input  logic                wr_hit,
  input  logic [RUN_W-1:0]    left_run,
  input  logic [RUN_W-1:0]    left_best,
  output logic [RUN_W-1:0]    run,
  output logic [RUN_W-1:0]    best,
  output logic                act
);
  import lcss_pkg::*;

  logic [7:0]       q_r;
  logic             act_r, act_nxt;
  logic [RUN_W-1:0] run_r, run_nxt;
  logic [RUN_W-1:0] best_r, best_nxt;
  logic [RUN_W-1:0] side_max;

  // occupancy of this position in the current query
  always_comb begin
    act_nxt = act_r;
    if (ctrl.wr_en) begin
      act_nxt = ctrl.restart ? wr_hit : (act_r | wr_hit);
    end
  end

  // run length of the common run ending at this position
  always_comb begin
    run_nxt = run_r;
    if (ctrl.clear) begin
      run_nxt = '0;
    end else if (ctrl.step) begin
      run_nxt = (act_r && (q_r == ctrl.byte_val)) ? left_run + RUN_W'(1) : '0;
    end
  end

  // best so far, moved one position down the row each cycle
  always_comb begin
    side_max = (left_best > run_r) ? left_best : run_r;
    best_nxt = (side_max > best_r) ? side_max : best_r;
    if (ctrl.clear) begin
      best_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      run_r  <= '0;
      best_r <= '0;
    end else begin
      act_r  <= act_nxt;
      run_r  <= run_nxt;
      best_r <= best_nxt;
    end
  end

  // query byte storage
  always_ff @(posedge clk) begin
    if (wr_hit) begin
      q_r <= ctrl.byte_val;
    end
  end

  assign run  = run_r;
  assign best = best_r;
  assign act  = act_r;

endmodule

[design/longest_common_substring_stream_core.sv]
// ----------------------------------------------------------------------------
// longest_common_substring_stream_core
// streaming longest common substring length between a stored query and lines
// ----------------------------------------------------------------------------
// A query (cmd 0) is loaded one word per cycle while the input is ready, up to
// QUERY_MAX bytes; text line words (cmd 1) are then taken one per cycle on the
// same terms, and every line end gives one result word with the longest common
// run and the counted line length. A line end holds the input off while the
// best run of each cell moves one position per cycle along the row of QUERY_MAX
// cells to the last cell, and then until the result register is loaded, which
// waits while the previous result word has not been taken.
// ----------------------------------------------------------------------------
module longest_common_substring_stream_core #(
  parameter int QUERY_MAX = 128,
  parameter int LINE_MAX  = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_cmd,
  input  logic [7:0]                         in_data_byte,
  input  logic                               in_last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [lcss_pkg::MATCH_W-1:0]       out_match_length,
  output logic [lcss_pkg::LINE_BYTES_W-1:0]  out_line_bytes
);
  import lcss_pkg::*;

  `include "longest_common_substring_stream_core_assert.svh"

  localparam int RUN_W   = $clog2(QUERY_MAX + 1);
  localparam int QLEN_W  = $clog2(QUERY_MAX + 1);
  localparam int IDX_W   = (QUERY_MAX > 1) ? $clog2(QUERY_MAX) : 1;
  localparam int CNT_W   = $clog2(LINE_MAX + 1);
  localparam int DRAIN_W = $clog2(QUERY_MAX + 1);
  localparam int MW      = (RUN_W > MATCH_W) ? RUN_W : MATCH_W;
  localparam int LW      = (CNT_W > LINE_BYTES_W) ? CNT_W : LINE_BYTES_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_SEND
  } state_t;

  state_t                   st_r, st_nxt;
  logic [QLEN_W-1:0]        qlen_r, qlen_nxt;
  logic                     qdone_r, qdone_nxt;
  logic                     stopped_r, stopped_nxt;
  logic [CNT_W-1:0]         line_cnt_r, line_cnt_nxt;
  logic [DRAIN_W-1:0]       drain_r, drain_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [MATCH_W-1:0]       out_match_r, out_match_nxt;
  logic [LINE_BYTES_W-1:0]  out_bytes_r, out_bytes_nxt;

  logic                     in_acc, is_qry, is_line, printable, send_fire;
  logic [QLEN_W-1:0]        wr_pos;
  logic [IDX_W-1:0]         wr_idx;
  cell_ctrl_t               ctrl;
  logic [MW-1:0]            best_ext;
  logic [LW-1:0]            cnt_ext;

  logic [RUN_W-1:0]         run_w  [QUERY_MAX];
  logic [RUN_W-1:0]         best_w [QUERY_MAX];
  logic [QUERY_MAX-1:0]     act_w;

  // input decode
  assign in_ready  = (st_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign is_qry    = in_acc && (in_cmd == CMD_QUERY);
  assign is_line   = in_acc && (in_cmd == CMD_LINE);
  assign printable = (in_data_byte >= PRINT_LO) && (in_data_byte <= PRINT_HI);
  assign send_fire = (st_r == ST_SEND) && (!out_valid_r || out_ready);

  // query write position: a new query starts at position zero
  assign wr_pos = (is_qry && qdone_r) ? '0 : qlen_r;
  assign wr_idx = wr_pos[IDX_W-1:0];

  // control broadcast to the cell row
  always_comb begin
    ctrl.clear    = is_qry || send_fire;
    ctrl.step     = is_line && printable && !stopped_r;
    ctrl.wr_en    = is_qry && (wr_pos < QLEN_W'(QUERY_MAX));
    ctrl.restart  = is_qry && qdone_r;
    ctrl.byte_val = in_data_byte;
  end

  // row of cells, one per query position
  for (genvar k = 0; k < QUERY_MAX; k++) begin : g_cell
    logic [RUN_W-1:0] left_run, left_best;
    logic             hit;
    if (k == 0) begin : g_head
      assign left_run  = '0;
      assign left_best = '0;
    end else begin : g_body
      assign left_run  = run_w[k-1];
      assign left_best = best_w[k-1];
    end
    assign hit = ctrl.wr_en && (wr_idx == IDX_W'(k));
    lcss_cell #(
      .RUN_W (RUN_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .wr_hit    (hit),
      .left_run  (left_run),
      .left_best (left_best),
      .run       (run_w[k]),
      .best      (best_w[k]),
      .act       (act_w[k])
    );
  end

  // widen the collected best and the line count for the clamp to the result widths
  assign best_ext = MW'(best_w[QUERY_MAX-1]);
  assign cnt_ext  = LW'(line_cnt_r);

  // query length, line counters and sequencer
  always_comb begin
    qlen_nxt      = qlen_r;
    qdone_nxt     = qdone_r;
    stopped_nxt   = stopped_r;
    line_cnt_nxt  = line_cnt_r;
    st_nxt        = st_r;
    drain_nxt     = drain_r;
    out_valid_nxt = out_valid_r;
    out_match_nxt = out_match_r;
    out_bytes_nxt = out_bytes_r;

    // query bytes
    if (is_qry) begin
      qlen_nxt  = (wr_pos < QLEN_W'(QUERY_MAX)) ? wr_pos + QLEN_W'(1) : wr_pos;
      qdone_nxt = in_last;
    end
    if (is_line) begin
      qdone_nxt = 1'b1;
    end

    // line bytes
    if (is_line && !stopped_r && !printable) begin
      stopped_nxt = 1'b1;
    end
    if (ctrl.step && (line_cnt_r < CNT_W'(LINE_MAX))) begin
      line_cnt_nxt = line_cnt_r + CNT_W'(1);
    end
    if (ctrl.clear) begin
      stopped_nxt  = 1'b0;
      line_cnt_nxt = '0;
    end

    // result word handshake
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (st_r)
      ST_IDLE: begin
        if (is_line && in_last) begin
          st_nxt    = ST_DRAIN;
          drain_nxt = '0;
        end
      end
      ST_DRAIN: begin
        if (drain_r == DRAIN_W'(QUERY_MAX - 1)) begin
          st_nxt = ST_SEND;
        end else begin
          drain_nxt = drain_r + DRAIN_W'(1);
        end
      end
      ST_SEND: begin
        if (send_fire) begin
          st_nxt        = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_match_nxt = (best_ext > MW'(MATCH_MAX)) ? MATCH_W'(MATCH_MAX)
                                                      : best_ext[MATCH_W-1:0];
          out_bytes_nxt = (cnt_ext > LW'(BYTES_MAX)) ? LINE_BYTES_W'(BYTES_MAX)
                                                     : cnt_ext[LINE_BYTES_W-1:0];
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      qlen_r      <= '0;
      qdone_r     <= 1'b1;
      stopped_r   <= 1'b0;
      line_cnt_r  <= '0;
      drain_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      qlen_r      <= qlen_nxt;
      qdone_r     <= qdone_nxt;
      stopped_r   <= stopped_nxt;
      line_cnt_r  <= line_cnt_nxt;
      drain_r     <= drain_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_match_r <= out_match_nxt;
    out_bytes_r <= out_bytes_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_match_length = out_match_r;
  assign out_line_bytes   = out_bytes_r;

  // checks
  `LCSS_ASSERT_ALWAYS(a_act_matches_qlen, $countones(act_w) == int'(qlen_r),
    "occupied cells disagree with query length")
  `LCSS_ASSERT_NEXT(a_line_end_drains, is_line && in_last, st_r == ST_DRAIN,
    "line end did not start the drain")
  `LCSS_ASSERT_NEXT(a_query_clears_line, is_qry, (line_cnt_r == '0) && !stopped_r,
    "query word left line state behind")
  `LCSS_ASSERT_NEXT(a_send_loads_word, send_fire, out_valid_r && (st_r == ST_IDLE),
    "result word not loaded after drain")

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the longest common substring stream core
// ----------------------------------------------------------------------------
// A short directed sequence covers the corner cases. It is followed by random
// queries and text lines built from pieces of the current query. A scoreboard
// predicts match length and line length for every line end and checks each
// result word in order. Both sides idle in random bursts. Once, the result
// side holds off long enough to back the core up. Three times, the sender
// waits until every pending result has drained.
// ----------------------------------------------------------------------------
module tb_top;
  import lcss_pkg::*;

  localparam int QMAX        = 128;
  localparam int LMAX        = 1024;
  localparam int TOTAL_WORDS = 1600;
  localparam int CALM_WORDS  = 250;
  localparam int HOLD_CYCLES = 1500;
  localparam int HOLD_AFTER  = 9;
  localparam int STALL_LIMIT = 8000;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic                    in_cmd;
  logic [7:0]              in_data_byte;
  logic                    in_last;
  logic                    out_valid;
  logic                    out_ready;
  logic [MATCH_W-1:0]      out_match_length;
  logic [LINE_BYTES_W-1:0] out_line_bytes;

  longest_common_substring_stream_core #(
    .QUERY_MAX (QMAX),
    .LINE_MAX  (LMAX)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_data_byte     (in_data_byte),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_match_length (out_match_length),
    .out_line_bytes   (out_line_bytes)
  );

  typedef struct {
    logic [MATCH_W-1:0]      match_length;
    logic [LINE_BYTES_W-1:0] line_bytes;
  } line_score_t;

  // tracks query and line state, predicts one score per line end
  class lcs_scoreboard;
    logic [7:0]  qbytes [QMAX];
    int unsigned qlen;
    bit          qdone;
    int unsigned run_len [QMAX];
    int unsigned longest;
    int unsigned counted;
    bit          halted;
    line_score_t line_scores [$];
    int unsigned errors;
    int unsigned scores_seen;

    function new();
      foreach (qbytes[k]) qbytes[k] = 8'h00;
      qlen        = 0;
      qdone       = 1'b1;
      errors      = 0;
      scores_seen = 0;
      reset_line();
    endfunction

    function void reset_line();
      foreach (run_len[k]) run_len[k] = 0;
      longest = 0;
      counted = 0;
      halted  = 1'b0;
    endfunction

    // one printable line byte: every cell extends or breaks its run
    function void advance_runs(logic [7:0] b);
      int k;
      int unsigned prev;
      for (k = int'(qlen) - 1; k >= 0; k--) begin
        if (qbytes[k] == b) begin
          prev       = (k > 0) ? run_len[k-1] : 0;
          run_len[k] = prev + 1;
          if (run_len[k] > longest) longest = run_len[k];
        end else begin
          run_len[k] = 0;
        end
      end
    endfunction

    function void note_word(logic cmd, logic [7:0] b, logic last);
      line_score_t score;
      if (cmd == CMD_QUERY) begin
        reset_line();
        if (qdone) begin
          qlen  = 0;
          qdone = 1'b0;
        end
        if (qlen < QMAX) begin
          qbytes[qlen] = b;
          qlen++;
        end
        if (last) qdone = 1'b1;
      end else begin
        qdone = 1'b1;
        if (!halted) begin
          if (b < PRINT_LO || b > PRINT_HI) begin
            halted = 1'b1;
          end else begin
            if (counted < LMAX) counted++;
            advance_runs(b);
          end
        end
        if (last) begin
          score.match_length = MATCH_W'((longest > MATCH_MAX) ? MATCH_MAX : longest);
          score.line_bytes   = LINE_BYTES_W'((counted > BYTES_MAX) ? BYTES_MAX : counted);
          line_scores.push_back(score);
          reset_line();
        end
      end
    endfunction

    function void check_result(logic [MATCH_W-1:0] ml, logic [LINE_BYTES_W-1:0] lb);
      line_score_t want;
      scores_seen++;
      if (line_scores.size() == 0) begin
        $display("%0t unexpected result word: match_length %0d line_bytes %0d",
                 $time, ml, lb);
        errors++;
        return;
      end
      want = line_scores.pop_front();
      if (ml !== want.match_length) begin
        $display("%0t mismatch match_length: expected %0d actual %0d",
                 $time, want.match_length, ml);
        errors++;
      end
      if (lb !== want.line_bytes) begin
        $display("%0t mismatch line_bytes: expected %0d actual %0d",
                 $time, want.line_bytes, lb);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return line_scores.size();
    endfunction
  endclass

  lcs_scoreboard sb;

  logic [7:0]  cur_q [QMAX];
  int unsigned cur_qlen;
  int unsigned words_sent;
  bit          calm;
  int unsigned tx_gap_pct;
  int unsigned rx_gap_pct;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side: random stalls plus one long hold-off
  initial begin : result_side
    int unsigned gap;
    int unsigned n;
    bit          held;
    out_ready = 1'b0;
    held      = 1'b0;
    n         = 0;
    rx_gap_pct = 0;
    forever begin
      @(negedge clk);
      n++;
      if (n % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: rx_gap_pct = 0;
          1: rx_gap_pct = 15;
          default: rx_gap_pct = 40;
        endcase
      end
      if (rst_n && !held && sb.scores_seen >= HOLD_AFTER) begin
        held      = 1'b1;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (!calm && rx_gap_pct != 0 && $urandom_range(1, 100) <= rx_gap_pct) begin
        gap       = $urandom_range(1, 13);
        out_ready = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // check every accepted result word
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_match_length, out_line_bytes);
  end

  // watchdog on cycles without any word moving
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t watchdog: no word moved for %0d cycles", $time, STALL_LIMIT);
    $display("FAIL");
    $finish;
  end

  // offer one input word, with an optional idle burst ahead of it
  task automatic offer_word(logic cmd, logic [7:0] b, logic last);
    int unsigned gap;
    if (words_sent % 50 == 0) begin
      case ($urandom_range(0, 2))
        0: tx_gap_pct = 0;
        1: tx_gap_pct = 10;
        default: tx_gap_pct = 35;
      endcase
    end
    if (!calm && tx_gap_pct != 0 && $urandom_range(1, 100) <= tx_gap_pct) begin
      gap      = $urandom_range(1, 13);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_cmd       = cmd;
    in_data_byte = b;
    in_last      = last;
    do @(posedge clk); while (!in_ready);
    sb.note_word(cmd, b, last);
    words_sent++;
    calm = (words_sent >= TOTAL_WORDS - CALM_WORDS);
    @(negedge clk);
  endtask

  // stop sending until every predicted score has come back
  task automatic drain_results();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] text_byte();
    if ($urandom_range(0, 99) < 55) return 8'h61 + 8'($urandom_range(0, 3));
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  function automatic logic [7:0] stop_byte();
    if ($urandom_range(0, 1) != 0) return 8'($urandom_range(8'h00, 8'h1F));
    return 8'($urandom_range(8'h7F, 8'hFF));
  endfunction

  task automatic send_query(int unsigned len, bit terminate);
    int unsigned i;
    logic [7:0]  b;
    for (i = 0; i < len; i++) begin
      b = ($urandom_range(0, 99) < 5) ? 8'($urandom_range(0, 255)) : text_byte();
      if (i < QMAX) cur_q[i] = b;
      offer_word(CMD_QUERY, b, terminate && (i == len - 1));
    end
    cur_qlen = (len < QMAX) ? len : QMAX;
  endtask

  // line made of query pieces and filler, maybe cut by a non-printable word
  task automatic send_line(int unsigned len, bit abort);
    int unsigned i;
    int unsigned stop_at;
    int unsigned copy_pos;
    int unsigned copy_left;
    logic [7:0]  b;
    stop_at   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : len;
    copy_left = 0;
    copy_pos  = 0;
    for (i = 0; i < len; i++) begin
      if (copy_left == 0 && cur_qlen != 0 && $urandom_range(0, 3) == 0) begin
        copy_pos  = $urandom_range(0, cur_qlen - 1);
        copy_left = $urandom_range(1, 16);
      end
      if (copy_left != 0 && copy_pos < cur_qlen) begin
        b = cur_q[copy_pos];
        copy_pos++;
        copy_left--;
      end else begin
        copy_left = 0;
        b         = text_byte();
      end
      if (i == stop_at) b = stop_byte();
      offer_word(CMD_LINE, b, !abort && (i == len - 1));
    end
  endtask

  function automatic int unsigned query_len_pick();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 8);
    if (r < 92) return $urandom_range(9, 40);
    if (r < 97) return $urandom_range(100, QMAX);
    return $urandom_range(QMAX + 1, QMAX + 12);
  endfunction

  function automatic int unsigned line_len_pick();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 1;
    if (r < 85) return $urandom_range(2, 30);
    return $urandom_range(31, 120);
  endfunction

  // main stimulus
  initial begin : stimulus
    int unsigned r;
    int unsigned lines;
    int unsigned j;
    bit          abort;
    bit          paused;
    sb           = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_cmd       = CMD_QUERY;
    in_data_byte = 8'h00;
    in_last      = 1'b0;
    words_sent   = 0;
    cur_qlen     = 0;
    calm         = 1'b0;
    tx_gap_pct   = 0;
    paused       = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // line against the empty query right after reset
    offer_word(CMD_LINE, 8'h61, 1'b1);
    // query with both printable extremes and non-printable bytes
    offer_word(CMD_QUERY, 8'h20, 1'b0);
    offer_word(CMD_QUERY, 8'h7E, 1'b0);
    offer_word(CMD_QUERY, 8'hFF, 1'b0);
    offer_word(CMD_QUERY, 8'h00, 1'b1);
    // line stops at a non-printable word, the rest is ignored
    offer_word(CMD_LINE, 8'h20, 1'b0);
    offer_word(CMD_LINE, 8'h7E, 1'b0);
    offer_word(CMD_LINE, 8'hFF, 1'b0);
    offer_word(CMD_LINE, 8'h20, 1'b1);
    // unprintable one-word lines just outside the printable range
    offer_word(CMD_LINE, 8'h1F, 1'b1);
    offer_word(CMD_LINE, 8'h7F, 1'b1);
    // query word in the middle of a line drops that line
    offer_word(CMD_LINE, 8'h7E, 1'b0);
    offer_word(CMD_QUERY, 8'h78, 1'b1);
    offer_word(CMD_LINE, 8'h78, 1'b1);
    // line words before the query end close the query as it stands
    offer_word(CMD_QUERY, 8'h6B, 1'b0);
    offer_word(CMD_QUERY, 8'h6D, 1'b0);
    offer_word(CMD_LINE, 8'h6B, 1'b0);
    offer_word(CMD_LINE, 8'h6D, 1'b1);
    // next query word starts over
    offer_word(CMD_QUERY, 8'h71, 1'b1);
    offer_word(CMD_LINE, 8'h6D, 1'b1);
    drain_results();

    // overlong query ending on a dropped word, then a saturating line
    send_query(QMAX + 12, 1'b1);
    send_line(LMAX + $urandom_range(1, 6), 1'b0);

    // random queries and lines
    while (words_sent < TOTAL_WORDS) begin
      if (!paused && words_sent >= TOTAL_WORDS / 2) begin
        paused = 1'b1;
        drain_results();
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
        offer_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)));
      end else begin
        if (r < 80 || cur_qlen == 0) send_query(query_len_pick(), $urandom_range(0, 19) != 0);
        lines = $urandom_range(1, 5);
        for (j = 0; j < lines; j++) begin
          abort = ($urandom_range(0, 19) == 0);
          send_line(line_len_pick(), abort);
          if (abort) break;
        end
      end
    end

    // wait for the tail, then let the core settle
    drain_results();
    repeat (QMAX + 10) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[longest_common_substring_stream_core.f]
+incdir+design
design/lcss_pkg.sv
design/lcss_cell.sv
design/longest_common_substring_stream_core.sv
verif/tb_top.sv
